FILE: rtl/tli_pkg.sv
// shared types and constants for the table linear interpolator
// no dependencies
`timescale 1ns / 1ps

package tli_pkg;

  localparam int unsigned NUM_ENTRIES = 16;
  localparam int unsigned ENTRY_IW    = 4;
  localparam int unsigned CFG_IW      = 3;
  localparam int unsigned CFG_DW      = 64;
  localparam int unsigned QDEPTH      = 2;

  localparam logic [CFG_IW-1:0] REG_Y_START    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_Y_INCR     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ENTRIES    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_X_POINTS_A = 3'd3;
  localparam logic [CFG_IW-1:0] REG_X_POINTS_B = 3'd4;
  localparam logic [CFG_IW-1:0] REG_X_POINTS_C = 3'd5;
  localparam logic [CFG_IW-1:0] REG_X_POINTS_D = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CLAMPED   = 3'd1;
  localparam logic [2:0] ST_ZERO_STEP = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_REPEAT    = 3'd4;

  typedef logic [NUM_ENTRIES-1:0][15:0] xtab_t;

  typedef struct packed {
    logic               is_div;
    logic signed [15:0] base;
    logic [2:0]         st;
    logic signed [16:0] dx;
    logic signed [16:0] span;
    logic signed [16:0] half;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_CLASS
  } fstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_FIX,
    B_DONE
  } bstate_t;

endpackage

FILE: rtl/tli_front.sv
// front end: accepts x, checks the table, searches the segment, builds a job
// depends on tli_pkg
`timescale 1ns / 1ps

module tli_front #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        x_in,
  output logic               busy,
  input  logic signed [15:0] y_start,
  input  logic signed [15:0] y_incr,
  input  logic [4:0]         entries,
  input  tli_pkg::xtab_t     tab,
  input  logic               q_full,
  output logic               push,
  output tli_pkg::job_t      job
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  tli_pkg::fstate_t state_r, state_nxt;
  logic [15:0]      x_r, x_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] seg_r, seg_nxt;
  logic             found_r, found_nxt;
  logic             dup_r, dup_nxt;

  logic [CNT_W-1:0]             n_eff;
  logic                         short_tab;
  logic [15:0]                  e_first, e_last, e_cur, e_prev, e_lo, e_hi;
  logic                         asc;
  logic                         clamp_lo, clamp_hi;
  logic [tli_pkg::ENTRY_IW-1:0] k4;
  logic signed [20:0]           kprod;

  assign n_eff     = (entries > 5'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries);
  assign short_tab = (y_incr == 16'sd0) || (n_eff < CNT_W'(2));
  assign e_first   = tab[0];
  assign e_last    = tab[tli_pkg::ENTRY_IW'(n_eff - CNT_W'(1))];
  assign e_cur     = tab[tli_pkg::ENTRY_IW'(i_r)];
  assign e_prev    = tab[tli_pkg::ENTRY_IW'(i_r - CNT_W'(1))];
  assign e_lo      = tab[tli_pkg::ENTRY_IW'(seg_r - CNT_W'(1))];
  assign e_hi      = tab[tli_pkg::ENTRY_IW'(seg_r)];
  assign asc       = e_first < e_last;
  assign clamp_lo  = asc ? (x_r <= e_first) : (x_r >= e_first);
  assign clamp_hi  = asc ? (x_r >= e_last) : (x_r <= e_last);
  assign k4        = clamp_hi ? tli_pkg::ENTRY_IW'(n_eff - CNT_W'(1))
                              : tli_pkg::ENTRY_IW'(seg_r - CNT_W'(1));
  assign kprod     = $signed({1'b0, k4}) * y_incr;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tli_pkg::F_IDLE:  if (start) state_nxt = tli_pkg::F_SCAN;
      tli_pkg::F_SCAN:  if (short_tab || i_r == n_eff) state_nxt = tli_pkg::F_CLASS;
      tli_pkg::F_CLASS: if (!q_full) state_nxt = tli_pkg::F_IDLE;
      default:          state_nxt = tli_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    x_nxt     = x_r;
    i_nxt     = i_r;
    seg_nxt   = seg_r;
    found_nxt = found_r;
    dup_nxt   = dup_r;
    case (state_r)
      tli_pkg::F_IDLE: begin
        x_nxt     = x_in;
        i_nxt     = CNT_W'(1);
        seg_nxt   = n_eff - CNT_W'(1);
        found_nxt = 1'b0;
        dup_nxt   = 1'b0;
      end
      tli_pkg::F_SCAN: begin
        if (!short_tab && i_r != n_eff) begin
          if (e_cur == e_prev) dup_nxt = 1'b1;
          if (!found_r && i_r < n_eff - CNT_W'(1) &&
              !(asc ? (x_r > e_cur) : (x_r < e_cur))) begin
            seg_nxt   = i_r;
            found_nxt = 1'b1;
          end
          i_nxt = i_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // classify the request
  always_comb begin
    job      = '0;
    job.dx   = $signed({1'b0, x_r}) - $signed({1'b0, e_lo});
    job.span = $signed({1'b0, e_hi}) - $signed({1'b0, e_lo});
    job.half = job.span >>> 1;
    if (y_incr == 16'sd0) begin
      job.st = tli_pkg::ST_ZERO_STEP;
    end else if (n_eff < CNT_W'(2)) begin
      job.st = tli_pkg::ST_SHORT;
    end else if (dup_r) begin
      job.st = tli_pkg::ST_REPEAT;
    end else if (clamp_lo) begin
      job.base = y_start;
      job.st   = (x_r == e_first) ? tli_pkg::ST_OK : tli_pkg::ST_CLAMPED;
    end else if (clamp_hi) begin
      job.base = y_start + kprod[15:0];
      job.st   = (x_r == e_last) ? tli_pkg::ST_OK : tli_pkg::ST_CLAMPED;
    end else begin
      job.is_div = 1'b1;
      job.base   = y_start + kprod[15:0];
      job.st     = tli_pkg::ST_OK;
    end
  end

  assign push = (state_r == tli_pkg::F_CLASS) && !q_full;
  assign busy = (state_r != tli_pkg::F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tli_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r     <= x_nxt;
    i_r     <= i_nxt;
    seg_r   <= seg_nxt;
    found_r <= found_nxt;
    dup_r   <= dup_nxt;
  end

endmodule

FILE: rtl/tli_queue.sv
// short job queue between front and back end
// depends on tli_pkg
`timescale 1ns / 1ps

module tli_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tli_pkg::job_t wr_job,
  input  logic          pop,
  output tli_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PW = $clog2(tli_pkg::QDEPTH);

  tli_pkg::job_t mem_r [tli_pkg::QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full   = (cnt_r == (PW+1)'(tli_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(tli_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

FILE: rtl/tli_back.sv
// back end: multiply, serial signed division, final sum, result register
// depends on tli_pkg
`timescale 1ns / 1ps

module tli_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] y_incr,
  input  logic               q_empty,
  input  tli_pkg::job_t      q_job,
  output logic               pop,
  output logic               out_strobe,
  output logic signed [15:0] out_y,
  output logic [2:0]         out_st
);

  tli_pkg::bstate_t   state_r, state_nxt;
  tli_pkg::job_t      job_r, job_nxt;
  logic               neg_r, neg_nxt;
  logic [16:0]        den_r, den_nxt;
  logic [16:0]        rem_r, rem_nxt;
  logic [33:0]        quo_r, quo_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic signed [15:0] y_r, y_nxt;
  logic [2:0]         st_r, st_nxt;

  logic signed [33:0] num;
  logic [17:0]        trial;
  logic [15:0]        q16;

  assign num   = (34'(job_r.dx) * 34'(y_incr)) + 34'(job_r.half);
  assign trial = {rem_r, quo_r[33]};
  assign q16   = neg_r ? (16'd0 - quo_r[15:0]) : quo_r[15:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tli_pkg::B_IDLE: if (!q_empty) state_nxt = q_job.is_div ? tli_pkg::B_MUL : tli_pkg::B_DONE;
      tli_pkg::B_MUL:  state_nxt = tli_pkg::B_DIV;
      tli_pkg::B_DIV:  if (cnt_r == 6'd33) state_nxt = tli_pkg::B_FIX;
      tli_pkg::B_FIX:  state_nxt = tli_pkg::B_DONE;
      tli_pkg::B_DONE: state_nxt = tli_pkg::B_IDLE;
      default:         state_nxt = tli_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_nxt = job_r;
    neg_nxt = neg_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    y_nxt   = y_r;
    st_nxt  = st_r;
    case (state_r)
      tli_pkg::B_IDLE: begin
        job_nxt = q_job;
        y_nxt   = q_job.base;
        st_nxt  = q_job.st;
      end
      tli_pkg::B_MUL: begin
        neg_nxt = num[33] ^ job_r.span[16];
        quo_nxt = num[33] ? (34'd0 - num) : num;
        den_nxt = job_r.span[16] ? (17'd0 - job_r.span) : job_r.span;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      tli_pkg::B_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = 17'(trial - {1'b0, den_r});
          quo_nxt = {quo_r[32:0], 1'b1};
        end else begin
          rem_nxt = trial[16:0];
          quo_nxt = {quo_r[32:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
      end
      tli_pkg::B_FIX: begin
        y_nxt  = job_r.base + $signed(q16);
        st_nxt = job_r.st;
      end
      default: ;
    endcase
  end

  assign pop        = (state_r == tli_pkg::B_IDLE) && !q_empty;
  assign out_strobe = (state_r == tli_pkg::B_DONE);
  assign out_y      = y_r;
  assign out_st     = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tli_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r <= job_nxt;
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    y_r   <= y_nxt;
    st_r  <= st_nxt;
  end

endmodule

FILE: rtl/table_linear_interpolator_unit.sv
// top level of the table linear interpolator: config registers, front, queue, back
// depends on tli_pkg, tli_front, tli_queue, tli_back
`timescale 1ns / 1ps

// Maps an unsigned 16-bit x through a table of up to 16 x breakpoints with
// evenly spaced y values, clamping outside the table and interpolating inside.
// Requests: drive in_x_in and pulse start; taken on a rising edge with busy low.
// Results: out_strobe is high for one cycle with out_y_out and out_status.
// The receiver cannot stall; every request gives exactly one result.
// Config: cfg_we, cfg_index, cfg_data write registers 0..6; write only when idle.
// Flow: the front end scans the table one entry per cycle, then the back end
// runs a multiply step, a serial restoring division, a fix step and an output
// step; table errors and clamped requests skip the division.
// A two-entry queue lets the front end take the next request while the back
// end divides, so sustained throughput for interpolated requests is set by
// the serial divider.
// Reset clears the config registers to zero, returns both ends to idle and
// empties the queue.

module table_linear_interpolator_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [15:0]                       in_x_in,
  output logic                              out_strobe,
  output logic signed [15:0]                out_y_out,
  output logic [2:0]                        out_status,
  input  logic                              cfg_we,
  input  logic [tli_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [tli_pkg::CFG_DW-1:0]        cfg_data
);

  logic signed [15:0] y_start_r;
  logic signed [15:0] y_incr_r;
  logic [4:0]         entries_r;
  logic [3:0][63:0]   xw_r;
  tli_pkg::xtab_t     tab;

  logic          push, pop, q_full, q_empty;
  tli_pkg::job_t f_job, q_job;

  assign tab = tli_pkg::xtab_t'(xw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_start_r <= '0;
      y_incr_r  <= '0;
      entries_r <= '0;
      xw_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tli_pkg::REG_Y_START:    y_start_r <= cfg_data[15:0];
        tli_pkg::REG_Y_INCR:     y_incr_r  <= cfg_data[15:0];
        tli_pkg::REG_ENTRIES:    entries_r <= cfg_data[4:0];
        tli_pkg::REG_X_POINTS_A: xw_r[0]   <= cfg_data;
        tli_pkg::REG_X_POINTS_B: xw_r[1]   <= cfg_data;
        tli_pkg::REG_X_POINTS_C: xw_r[2]   <= cfg_data;
        tli_pkg::REG_X_POINTS_D: xw_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  tli_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .x_in    (in_x_in),
    .busy    (busy),
    .y_start (y_start_r),
    .y_incr  (y_incr_r),
    .entries (entries_r),
    .tab     (tab),
    .q_full  (q_full),
    .push    (push),
    .job     (f_job)
  );

  tli_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (f_job),
    .pop    (pop),
    .rd_job (q_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  tli_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .y_incr     (y_incr_r),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_y      (out_y_out),
    .out_st     (out_status)
  );

endmodule

FILE: tb/tb_table_linear_interpolator_unit.sv
// self-checking testbench for table_linear_interpolator_unit: random tables and lookups
// checked against a local predictor; depends on tli_pkg and the rtl under rtl/
`timescale 1ns / 1ps

module tb_table_linear_interpolator_unit;

  localparam logic [tli_pkg::CFG_IW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [15:0]        x;
    logic signed [15:0] y;
    logic [2:0]         st;
  } lookup_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [15:0]       in_x_in = '0;
  logic              out_strobe;
  logic signed [15:0] out_y_out;
  logic [2:0]        out_status;
  logic              cfg_we = 1'b0;
  logic [tli_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [tli_pkg::CFG_DW-1:0] cfg_data = '0;

  // local copy of the register file
  logic [15:0] m_y0, m_yinc;
  logic [4:0]  m_count;
  logic [15:0] m_xtab [tli_pkg::NUM_ENTRIES];

  logic [15:0] pending_x [$];
  lookup_t     expected_lookups [$];
  int          mismatches = 0;
  int          gap = 0;

  table_linear_interpolator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_x_in(in_x_in),
    .out_strobe(out_strobe), .out_y_out(out_y_out), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic lookup_t interpolate(logic [15:0] x);
    lookup_t r;
    longint y0, stp, first, last, lo, hi, dx, span, half, acc, xv;
    int n, i;
    bit asc;
    y0 = longint'($signed(m_y0));
    stp = longint'($signed(m_yinc));
    n = m_count > tli_pkg::NUM_ENTRIES ? tli_pkg::NUM_ENTRIES : m_count;
    xv = x;
    r.x = x;
    r.y = '0;
    if (stp == 0) begin
      r.st = tli_pkg::ST_ZERO_STEP;
      return r;
    end
    if (n < 2) begin
      r.st = tli_pkg::ST_SHORT;
      return r;
    end
    for (i = 1; i < n; i++) begin
      if (m_xtab[i] == m_xtab[i-1]) begin
        r.st = tli_pkg::ST_REPEAT;
        return r;
      end
    end
    first = m_xtab[0];
    last = m_xtab[n-1];
    asc = first < last;
    if (asc ? (xv <= first) : (xv >= first)) begin
      r.y = y0[15:0];
      r.st = (xv == first) ? tli_pkg::ST_OK : tli_pkg::ST_CLAMPED;
      return r;
    end
    if (asc ? (xv >= last) : (xv <= last)) begin
      acc = y0 + longint'(n - 1) * stp;
      r.y = acc[15:0];
      r.st = (xv == last) ? tli_pkg::ST_OK : tli_pkg::ST_CLAMPED;
      return r;
    end
    i = 1;
    while (i < n - 1 && (asc ? (xv > m_xtab[i]) : (xv < m_xtab[i]))) i++;
    lo = m_xtab[i-1];
    hi = m_xtab[i];
    dx = xv - lo;
    span = hi - lo;
    half = (span >= 0) ? span / 2 : -((-span + 1) / 2);
    acc = (dx * stp + half) / span + y0 + longint'(i - 1) * stp;
    r.y = acc[15:0];
    r.st = tli_pkg::ST_OK;
    return r;
  endfunction

  task automatic report(string what, logic [15:0] x, int got, int want);
    $display("mismatch %s for x=%0h: got %0d expected %0d", what, x, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_lookups.push_back(interpolate(in_x_in));
      gap = pick_gap();
      if (gap == 0 && pending_x.size() > 0) begin
        in_x_in <= pending_x.pop_front();
        gap = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap--;
      end else if (pending_x.size() > 0) begin
        in_x_in <= pending_x.pop_front();
        start <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lookup_t w;
    if (rst_n && out_strobe) begin
      if (expected_lookups.size() == 0) begin
        report("unexpected result", 16'h0, out_y_out, 0);
      end else begin
        w = expected_lookups.pop_front();
        if (out_y_out !== w.y) report("y_out", w.x, out_y_out, w.y);
        if (out_status !== w.st) report("status", w.x, out_status, w.st);
      end
    end
  end

  task automatic wait_idle();
    while (pending_x.size() > 0 || start || expected_lookups.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [tli_pkg::CFG_IW-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      tli_pkg::REG_Y_START:    m_y0 = data[15:0];
      tli_pkg::REG_Y_INCR:     m_yinc = data[15:0];
      tli_pkg::REG_ENTRIES:    m_count = data[4:0];
      tli_pkg::REG_X_POINTS_A: for (int k = 0; k < 4; k++) m_xtab[k] = data[16*k +: 16];
      tli_pkg::REG_X_POINTS_B: for (int k = 0; k < 4; k++) m_xtab[4+k] = data[16*k +: 16];
      tli_pkg::REG_X_POINTS_C: for (int k = 0; k < 4; k++) m_xtab[8+k] = data[16*k +: 16];
      tli_pkg::REG_X_POINTS_D: for (int k = 0; k < 4; k++) m_xtab[12+k] = data[16*k +: 16];
      default: ;
    endcase
  endtask

  // upper bits of narrow registers carry noise
  task automatic load_table(logic [15:0] y0, logic [15:0] yinc, logic [4:0] n,
                            logic [15:0] e [tli_pkg::NUM_ENTRIES]);
    logic [63:0] noise;
    wait_idle();
    noise = {$urandom, $urandom};
    write_reg(tli_pkg::REG_Y_START, {noise[63:16], y0});
    write_reg(tli_pkg::REG_Y_INCR, {noise[47:0], yinc});
    write_reg(tli_pkg::REG_ENTRIES, {noise[58:0], n});
    write_reg(tli_pkg::REG_X_POINTS_A, {e[3], e[2], e[1], e[0]});
    write_reg(tli_pkg::REG_X_POINTS_B, {e[7], e[6], e[5], e[4]});
    write_reg(tli_pkg::REG_X_POINTS_C, {e[11], e[10], e[9], e[8]});
    write_reg(tli_pkg::REG_X_POINTS_D, {e[15], e[14], e[13], e[12]});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] random_x();
    int n, k, r;
    logic [15:0] a, b;
    n = m_count > tli_pkg::NUM_ENTRIES ? tli_pkg::NUM_ENTRIES : m_count;
    r = $urandom_range(0, 9);
    if (n < 2 || r >= 8) return 16'($urandom);
    k = $urandom_range(0, n - 2);
    if (r >= 6) return m_xtab[$urandom_range(0, n - 1)];
    a = m_xtab[k];
    b = m_xtab[k+1];
    return (a < b) ? 16'($urandom_range(a, b)) : 16'($urandom_range(b, a));
  endfunction

  task automatic random_table(output logic [15:0] e [tli_pkg::NUM_ENTRIES],
                              output logic [4:0] n);
    int steps [tli_pkg::NUM_ENTRIES];
    int sum, base, lim, r;
    for (int k = 0; k < tli_pkg::NUM_ENTRIES; k++) e[k] = 16'($urandom);
    r = $urandom_range(0, 99);
    n = (r < 85) ? 5'($urandom_range(2, tli_pkg::NUM_ENTRIES)) : 5'($urandom);
    if (r >= 92) return;
    lim = ($urandom_range(0, 3) == 0) ? 65535 / (tli_pkg::NUM_ENTRIES - 1)
                                      : 65535 / 15 / 8;
    if (n >= 2 && n <= tli_pkg::NUM_ENTRIES && $urandom_range(0, 3) == 0)
      lim = 65535 / (n - 1);
    sum = 0;
    for (int k = 1; k < tli_pkg::NUM_ENTRIES; k++) begin
      steps[k] = $urandom_range(1, lim);
      if (sum + steps[k] > 65535) steps[k] = 1;
      sum += steps[k];
    end
    base = $urandom_range(0, 65535 - sum);
    e[0] = 16'(base);
    for (int k = 1; k < tli_pkg::NUM_ENTRIES; k++) e[k] = e[k-1] + 16'(steps[k]);
    if (r < 45) begin
      for (int k = 0; k < tli_pkg::NUM_ENTRIES / 2; k++) begin
        logic [15:0] t;
        t = e[k];
        e[k] = e[tli_pkg::NUM_ENTRIES-1-k];
        e[tli_pkg::NUM_ENTRIES-1-k] = t;
      end
      if (n >= 2 && n <= tli_pkg::NUM_ENTRIES)
        for (int k = 0; k < n; k++) e[k] = e[tli_pkg::NUM_ENTRIES - n + k];
    end
  endtask

  initial begin
    logic [15:0] e [tli_pkg::NUM_ENTRIES];
    logic [4:0] n;
    logic [15:0] y0, yi;
    int r;

    m_y0 = '0;
    m_yinc = '0;
    m_count = '0;
    for (int k = 0; k < tli_pkg::NUM_ENTRIES; k++) m_xtab[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: zero step
    pending_x.push_back(16'h0000);
    pending_x.push_back(16'hffff);

    // ascending full table, steepest steps
    for (int k = 0; k < tli_pkg::NUM_ENTRIES; k++) e[k] = 16'(k * 4000 + 100);
    load_table(16'h8000, 16'h7fff, 5'd16, e);
    write_reg(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    @(posedge clk);
    cfg_we <= 1'b0;
    pending_x.push_back(16'h0000);
    pending_x.push_back(16'd100);
    pending_x.push_back(16'd2101);
    pending_x.push_back(16'd60100);
    pending_x.push_back(16'hffff);
    pending_x.push_back(16'd30000);

    // descending two-entry table, full span, most negative step
    for (int k = 0; k < tli_pkg::NUM_ENTRIES; k++) e[k] = 16'($urandom);
    e[0] = 16'hffff;
    e[1] = 16'h0000;
    load_table(16'h7fff, 16'h8000, 5'd2, e);
    pending_x.push_back(16'hffff);
    pending_x.push_back(16'h0000);
    pending_x.push_back(16'h8000);
    pending_x.push_back(16'h0001);

    // count above table depth treated as full depth
    for (int k = 0; k < tli_pkg::NUM_ENTRIES; k++) e[k] = 16'(60000 - k * 3000);
    load_table(16'h0005, 16'hfffd, 5'd31, e);
    pending_x.push_back(16'd14000);
    pending_x.push_back(16'd61000);
    pending_x.push_back(16'd1000);

    // short table and repeated entries
    load_table(16'h0001, 16'h0001, 5'd1, e);
    pending_x.push_back(16'd5);
    load_table(16'h0001, 16'h0001, 5'd0, e);
    pending_x.push_back(16'd5);
    e[5] = e[4];
    load_table(16'h0001, 16'h0001, 5'd16, e);
    pending_x.push_back(16'd5);

    // non-monotonic shape
    e[0] = 16'd100; e[1] = 16'd900; e[2] = 16'd300; e[3] = 16'd1000;
    load_table(16'hff00, 16'h0100, 5'd4, e);
    pending_x.push_back(16'd600);
    pending_x.push_back(16'd950);

    for (int p = 0; p < 40; p++) begin
      random_table(e, n);
      r = $urandom_range(0, 9);
      y0 = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7fff : 16'($urandom);
      r = $urandom_range(0, 19);
      yi = (r == 0) ? 16'h0000 : (r == 1) ? 16'h8000 : (r == 2) ? 16'h7fff :
           (r < 10) ? 16'($urandom_range(0, 400)) - 16'd200 : 16'($urandom);
      if (yi == 0 && r != 0) yi = 16'd1;
      load_table(y0, yi, n, e);
      for (int k = 0; k < 36; k++) pending_x.push_back(random_x());
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
